/* rtl/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and helper functions for the population convergence check.
// ----------------------------------------------------------------------------
`default_nettype none
package pcc_pkg;

  localparam int unsigned COORD_MAX = 8;
  localparam logic [32:0] ONE_Q16 = 33'h0_0001_0000;

  // configuration register indexes
  localparam logic [1:0] REG_COST_TOL = 2'd0;
  localparam logic [1:0] REG_GEOM_TOL = 2'd1;
  localparam logic [1:0] REG_COORDS   = 2'd2;

  // deciding test codes
  localparam logic [1:0] TEST_BEST_SMALL = 2'd0;
  localparam logic [1:0] TEST_SPREAD     = 2'd1;
  localparam logic [1:0] TEST_GEOM       = 2'd2;
  localparam logic [1:0] TEST_ALL_PASS   = 2'd3;

  // classified word between front and back
  typedef struct packed {
    logic                   load;
    logic                   last;
    logic [COORD_MAX-1:0]   viol;
    logic [31:0]            cost;
    logic [15:0]            limit;
    logic [31:0]            cost_tol;
  } word_t;

  function automatic logic [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return e[32] ? 33'(-e) : 33'(e);
  endfunction

  // difference of two signed words needs 34 bits; its magnitude fits in 33
  function automatic logic [32:0] absdiff33(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [33:0] d;
    d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    return d[33] ? 33'(-d) : 33'(d);
  endfunction

endpackage
`default_nettype wire

/* rtl/pcc_scale.sv */
// ----------------------------------------------------------------------------
// pcc_scale
// Registered relative tolerance: tol * mag >> 16 with saturation, or tol when mag <= 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module pcc_scale (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic [31:0] tol,
  input  wire logic [32:0] mag,
  output logic [31:0]      scaled
);
  import pcc_pkg::*;

  logic [64:0] prod;
  logic [48:0] shr;

  // magnitude stays below 2^32, so the product fits in 64 bits
  always_comb begin
    prod = 65'(tol) * 65'(mag);
    shr  = prod[64:16];
  end

  // held between loads
  always_ff @(posedge clk) begin
    if (rst) begin
      scaled <= '0;
    end else if (en) begin
      if (mag <= ONE_Q16) begin
        scaled <= tol;
      end else if (|shr[48:32]) begin
        scaled <= 32'hFFFF_FFFF;
      end else begin
        scaled <= shr[31:0];
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/pcc_front.sv */
// ----------------------------------------------------------------------------
// pcc_front
// Accepts words, keeps best coordinates and tolerances, flags violations.
// ----------------------------------------------------------------------------
`default_nettype none
module pcc_front #(
  parameter int COORD_COUNT = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   mode,
  input  wire logic [31:0]            coord [pcc_pkg::COORD_MAX],
  input  wire logic [31:0]            member_cost,
  input  wire logic [15:0]            check_limit,
  input  wire logic                   pass_end,
  input  wire logic [31:0]            cost_tol,
  input  wire logic [31:0]            shape_tol,
  input  wire logic [3:0]             coords_used,
  output logic                        q_valid,
  output pcc_pkg::word_t              q_word,
  input  wire logic                   q_stall
);
  import pcc_pkg::*;

  logic        busy;         // scaled tolerances not yet ready after a load
  logic [31:0] best_c [COORD_MAX];
  logic [31:0] gtol   [COORD_MAX];
  logic [31:0] lead_cost;
  logic [31:0] ctol;
  logic        acc;
  logic [COORD_MAX-1:0] viol;
  logic [3:0]  n_use;

  assign in_stall = (q_valid && q_stall) || busy;
  assign acc      = in_valid && !in_stall;
  assign n_use    = (coords_used > 4'(COORD_COUNT)) ? 4'(COORD_COUNT) : coords_used;

  // tolerance scaling units, written the cycle after a load
  for (genvar g = 0; g < COORD_MAX; g++) begin : g_scale
    pcc_scale u_sc (.clk(clk), .rst(rst), .en(busy), .tol(shape_tol),
                    .mag(abs33(best_c[g])), .scaled(gtol[g]));
  end
  pcc_scale u_csc (.clk(clk), .rst(rst), .en(busy), .tol(cost_tol),
                   .mag({1'b0, lead_cost}), .scaled(ctol));

  // per-coordinate distance check
  always_comb begin
    for (int i = 0; i < COORD_MAX; i++) begin
      viol[i] = (i < int'(n_use)) &&
                (absdiff33(best_c[i], coord[i]) > {1'b0, gtol[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      q_valid   <= 1'b0;
      lead_cost <= '0;
      for (int i = 0; i < COORD_MAX; i++) best_c[i] <= '0;
    end else begin
      busy <= acc && !mode;
      if (acc && !mode) begin
        for (int i = 0; i < COORD_MAX; i++) best_c[i] <= coord[i];
        lead_cost <= member_cost;
      end
      if (acc) begin
        q_valid <= 1'b1;
      end else if (!q_stall) begin
        q_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (acc) begin
      q_word.load      <= !mode;
      q_word.last      <= pass_end;
      q_word.viol      <= viol;
      q_word.cost      <= member_cost;
      q_word.limit     <= check_limit;
      q_word.cost_tol  <= ctol;
    end
  end

  // a load always stalls the input in the cycle after it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (acc && !mode) |=> in_stall) else $error("load not followed by stall");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_stall) |=> q_valid) else $error("queue word dropped");
  a_nouse: assert property (@(posedge clk) disable iff (rst)
    (n_use == 4'd0) |-> (viol == '0))
    else $error("violation with no coordinates in use");
endmodule
`default_nettype wire

/* rtl/pcc_back.sv */
// ----------------------------------------------------------------------------
// pcc_back
// Tracks worst cost and violations per pass; issues the verdict word.
// ----------------------------------------------------------------------------
`default_nettype none
module pcc_back #(
  parameter int INDEX_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  pcc_pkg::word_t      q_word,
  output logic                q_stall,
  input  wire logic [31:0]    cost_tol,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                converged,
  output logic [1:0]          deciding_test
);
  import pcc_pkg::*;

  logic [INDEX_BITS-1:0] limit_index, member_index;
  logic [31:0] peak_cost, cost_at_limit, lead_cost;
  logic        limit_reached, gfail_pre, gfail_all;
  logic        take, emit, fail, at_lim, lim_nz;
  logic [31:0] w_cost, worst_n, cal_n, worst_sel;
  logic        lr_n, gp_n, ga_n, gsel;
  logic [31:0] spread;

  assign q_stall = out_valid && out_stall;
  assign take    = q_valid && !q_stall;
  assign emit    = take && !q_word.load && q_word.last;
  assign fail    = |q_word.viol;
  assign lim_nz  = |limit_index;
  assign at_lim  = lim_nz && (member_index == limit_index);
  assign w_cost  = q_word.cost;

  // next stream state for a member word
  always_comb begin
    worst_n   = (w_cost > peak_cost) ? w_cost : peak_cost;
    cal_n     = at_lim ? w_cost : cost_at_limit;
    lr_n      = limit_reached || at_lim;
    gp_n      = gfail_pre || (lim_nz && member_index <= limit_index && fail);
    ga_n      = gfail_all || fail;
    worst_sel = lr_n ? cal_n : worst_n;
    gsel      = lr_n ? gp_n : ga_n;
    // costs are unsigned
    spread    = (lead_cost >= worst_sel) ? lead_cost - worst_sel : worst_sel - lead_cost;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      limit_index   <= '0;
      member_index  <= '0;
      peak_cost     <= '0;
      cost_at_limit <= '0;
      limit_reached <= 1'b0;
      gfail_pre     <= 1'b0;
      gfail_all     <= 1'b0;
      lead_cost     <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take && q_word.load) begin
        limit_index   <= INDEX_BITS'(q_word.limit);
        lead_cost     <= q_word.cost;
        member_index  <= '0;
        peak_cost     <= '0;
        cost_at_limit <= '0;
        limit_reached <= 1'b0;
        gfail_pre     <= 1'b0;
        gfail_all     <= 1'b0;
      end else if (take) begin
        if (q_word.last) begin
          member_index  <= '0;
          peak_cost     <= '0;
          cost_at_limit <= '0;
          limit_reached <= 1'b0;
          gfail_pre     <= 1'b0;
          gfail_all     <= 1'b0;
          if (lead_cost < cost_tol) begin
            converged <= 1'b1; deciding_test <= TEST_BEST_SMALL;
          end else if (spread > q_word.cost_tol) begin
            converged <= 1'b0; deciding_test <= TEST_SPREAD;
          end else if (gsel) begin
            converged <= 1'b0; deciding_test <= TEST_GEOM;
          end else begin
            converged <= 1'b1; deciding_test <= TEST_ALL_PASS;
          end
        end else begin
          peak_cost     <= worst_n;
          cost_at_limit <= cal_n;
          limit_reached <= lr_n;
          gfail_pre     <= gp_n;
          gfail_all     <= ga_n;
          if (member_index != {INDEX_BITS{1'b1}}) member_index <= member_index + 1'b1;
        end
      end
    end
  end

  a_one: assert property (@(posedge clk) disable iff (rst)
    (take && q_word.last && !q_word.load) |=> out_valid)
    else $error("verdict missing");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (take && q_word.load) |=> (member_index == '0 && !limit_reached))
    else $error("pass state not cleared on load");
  a_lim: assert property (@(posedge clk) disable iff (rst)
    limit_reached |-> lim_nz) else $error("limit reached with zero limit");
endmodule
`default_nettype wire

/* rtl/population_convergence_check_top.sv */
// ----------------------------------------------------------------------------
// population_convergence_check_top
// Streaming convergence check of an optimizer population, Q16.16.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// input   | in        | in_valid/in_stall   | mode, coord_0..7, member_cost, ...
// output  | out       | out_valid/out_stall | converged, deciding_test
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// A member word is taken every cycle while in_stall is low; the verdict
// is registered in the back stage once the last member's word leaves the
// front register. A best-member load holds the input while the scaled
// tolerances are registered. Reset is synchronous and clears all pass
// state. Either side may stall; the front register parts them.
`default_nettype none
module population_convergence_check_top #(
  parameter int COORD_COUNT = 8,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [31:0] coord_0,
  input  wire logic [31:0] coord_1,
  input  wire logic [31:0] coord_2,
  input  wire logic [31:0] coord_3,
  input  wire logic [31:0] coord_4,
  input  wire logic [31:0] coord_5,
  input  wire logic [31:0] coord_6,
  input  wire logic [31:0] coord_7,
  input  wire logic [31:0] member_cost,
  input  wire logic [15:0] check_limit,
  input  wire logic        pass_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             converged,
  output logic [1:0]       deciding_test
);
  import pcc_pkg::*;

  logic [31:0] cost_tol, shape_tol;
  logic [3:0]  coords_used;
  logic [31:0] coord [COORD_MAX];
  logic        q_valid, q_stall;
  word_t       q_word;

  assign coord = '{coord_0, coord_1, coord_2, coord_3,
                   coord_4, coord_5, coord_6, coord_7};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_tol    <= 32'd1;
      shape_tol   <= 32'd1;
      coords_used <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COST_TOL: cost_tol    <= cfg_data;
        REG_GEOM_TOL: shape_tol   <= cfg_data;
        REG_COORDS:   coords_used <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  pcc_front #(.COORD_COUNT(COORD_COUNT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .coord, .member_cost,
    .check_limit, .pass_end, .cost_tol, .shape_tol, .coords_used,
    .q_valid, .q_word, .q_stall
  );

  pcc_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst, .q_valid, .q_word, .q_stall, .cost_tol,
    .out_valid, .out_stall, .converged, .deciding_test
  );
endmodule
`default_nettype wire
